/* hdl/generational_handle_table_assert.svh */
// Assertion macros used by the handle table controller.
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define GHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHT_ASSERT(lbl, clk, rst, prop, msg)
`define GHT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/ght_pkg.sv */
// Types and constants of the generational handle table.
package ght_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;

   localparam int PTR_W   = 64;
   localparam int TOKEN_W = 32;
   localparam int GEN_W   = 12;
   localparam int INDEX_W = 20;

   localparam logic [GEN_W-1:0] GEN_MIN = 12'h100;
   localparam logic [GEN_W-1:0] GEN_MAX = 12'hFFF;

   typedef enum logic [1:0] {
      REQ_REGISTER = 2'd0,
      REQ_RESOLVE  = 2'd1,
      REQ_RESET    = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NULL      = 2'd1,
      ST_BAD_TOKEN = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [INDEX_W-1:0] addr;
      logic [PTR_W-1:0]   wr_data;
   } mem_req_type;

endpackage

/* hdl/ght_store.sv */
// Pointer memory: one write and one registered read per cycle.
module ght_store #(
   parameter int TABLE_DEPTH = ght_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  ght_pkg::mem_req_type      mem_req,
   output logic [ght_pkg::PTR_W-1:0] rd_data
);
   import ght_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [PTR_W-1:0] mem [TABLE_DEPTH];
   logic [PTR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr[ADDR_W-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ght_ctrl.sv */
// Request decode, index and generation counters, and result register.
module ght_ctrl #(
   parameter int TABLE_DEPTH = ght_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [ght_pkg::PTR_W-1:0]   req_pointer_value,
   input  logic [ght_pkg::TOKEN_W-1:0] req_token_in,
   output ght_pkg::mem_req_type        mem_req,
   input  logic [ght_pkg::PTR_W-1:0]   rd_data,
   output logic                        rsp_valid,
   output logic [ght_pkg::TOKEN_W-1:0] rsp_token_out,
   output logic [ght_pkg::PTR_W-1:0]   rsp_pointer_out,
   output logic [1:0]                  rsp_status,
   output logic [ght_pkg::GEN_W-1:0]   rsp_generation_now
);
   import ght_pkg::*;
   `include "generational_handle_table_assert.svh"

   localparam int NEXT_W = $clog2(TABLE_DEPTH) + 1;
   localparam logic [NEXT_W-1:0] DEPTH_VAL = NEXT_W'(TABLE_DEPTH);
   localparam logic [NEXT_W-1:0] FIRST_IDX = NEXT_W'(1);

   logic                busy_ff;
   logic [NEXT_W-1:0]   next_free_ff, next_free_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic                valid_ff;
   logic [TOKEN_W-1:0]  token_ff, token_in;
   status_type          status_ff, status_in;
   logic [GEN_W-1:0]    gen_now_ff;
   logic                hit_ff, hit_in;
   logic                accept;
   logic [GEN_W-1:0]    tok_gen;
   logic [INDEX_W-1:0]  tok_idx;

   assign accept  = start && !busy_ff;
   assign tok_gen = req_token_in[TOKEN_W-1:INDEX_W];
   assign tok_idx = req_token_in[INDEX_W-1:0];

   always_comb begin
      next_free_in    = next_free_ff;
      gen_in          = gen_ff;
      token_in        = '0;
      status_in       = ST_OK;
      hit_in          = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.rd_en   = 1'b0;
      mem_req.addr    = INDEX_W'(next_free_ff);
      mem_req.wr_data = req_pointer_value;
      if (accept) begin
         case (req_code_type'(req_type))
            REQ_REGISTER: begin
               if (req_pointer_value == '0) begin
                  status_in = ST_NULL;
               end else if (next_free_ff >= DEPTH_VAL) begin
                  status_in = ST_FULL;
               end else begin
                  mem_req.wr_en = 1'b1;
                  next_free_in  = next_free_ff + FIRST_IDX;
                  token_in      = {gen_ff, INDEX_W'(next_free_ff)};
               end
            end
            REQ_RESOLVE: begin
               mem_req.addr = tok_idx;
               if (req_token_in == '0 || tok_gen != gen_ff || tok_idx == '0 ||
                   tok_idx >= INDEX_W'(next_free_ff)) begin
                  status_in = ST_BAD_TOKEN;
               end else begin
                  mem_req.rd_en = 1'b1;
                  hit_in        = 1'b1;
               end
            end
            REQ_RESET: begin
               next_free_in = FIRST_IDX;
               gen_in       = (gen_ff == GEN_MAX) ? GEN_MIN : gen_ff + GEN_W'(1);
            end
            default: begin
               // unused code: answer with zero token and pointer and status OK, change nothing
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         valid_ff     <= 1'b0;
         next_free_ff <= FIRST_IDX;
         gen_ff       <= GEN_MIN;
      end else begin
         busy_ff      <= 1'b0;
         valid_ff     <= accept;
         next_free_ff <= next_free_in;
         gen_ff       <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         token_ff   <= token_in;
         status_ff  <= status_in;
         gen_now_ff <= gen_in;
         hit_ff     <= hit_in;
      end
   end

   assign busy               = busy_ff;
   assign rsp_valid          = valid_ff;
   assign rsp_token_out      = token_ff;
   assign rsp_pointer_out    = hit_ff ? rd_data : '0;
   assign rsp_status         = status_ff;
   assign rsp_generation_now = gen_now_ff;

   `GHT_ASSERT(gen_in_range_a, clock, reset, gen_ff >= GEN_MIN, "generation below minimum")
   `GHT_ASSERT(next_free_range_a, clock, reset, next_free_ff != '0 && next_free_ff <= DEPTH_VAL, "next free index out of range")
   `GHT_ASSERT(rsp_follows_accept_a, clock, reset, accept |=> rsp_valid, "transfer accepted without response")
   `GHT_ASSERT(write_advances_index_a, clock, reset, mem_req.wr_en |=> next_free_ff == $past(next_free_ff) + FIRST_IDX, "register did not advance index")
   `GHT_ASSERT(no_rw_overlap_a, clock, reset, !(mem_req.wr_en && mem_req.rd_en), "memory read and write in one cycle")

endmodule

/* hdl/generational_handle_table.sv */
// Generational handle table: issues, resolves and invalidates pointer tokens.
//
// One request is taken on each clock at which start is high and busy is low;
// busy is high only while reset is held and for the cycle after it. The
// response appears on rsp_valid and the rsp_ fields in the cycle after the
// request transfer, as the pointer memory read is registered, so a new
// request may be issued every cycle. The receiver cannot
// stall: each response is present for that one cycle only and must be
// captured then. Tokens carry the generation in bits 31..20 and the index in
// bits 19..0; index 0 is never issued. The pointer memory is not cleared
// after reset, as an entry is only read after it is written in the current
// generation, so no clearing pass is needed.
module generational_handle_table #(
   parameter int TABLE_DEPTH = ght_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [ght_pkg::PTR_W-1:0]   req_pointer_value,
   input  logic [ght_pkg::TOKEN_W-1:0] req_token_in,
   output logic                        rsp_valid,
   output logic [ght_pkg::TOKEN_W-1:0] rsp_token_out,
   output logic [ght_pkg::PTR_W-1:0]   rsp_pointer_out,
   output logic [1:0]                  rsp_status,
   output logic [ght_pkg::GEN_W-1:0]   rsp_generation_now
);
   import ght_pkg::*;

   mem_req_type      mem_req;
   logic [PTR_W-1:0] rd_data;

   ght_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_pointer_value  (req_pointer_value),
      .req_token_in       (req_token_in),
      .mem_req            (mem_req),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_token_out      (rsp_token_out),
      .rsp_pointer_out    (rsp_pointer_out),
      .rsp_status         (rsp_status),
      .rsp_generation_now (rsp_generation_now)
   );

   ght_store #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the generational handle table.
`timescale 1ns / 1ps

module testbench;
   import ght_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 630;
   localparam int CYCLE_LIMIT = 300000;
   localparam int STALE_KEEP = 64;

   typedef struct {
      logic [TOKEN_W-1:0] token_out;
      logic [PTR_W-1:0]   pointer_out;
      status_type         status;
      logic [GEN_W-1:0]   generation_now;
   } handle_response_type;

   // Mirror of the table state plus the responses still owed by the block.
   class handle_scoreboard;
      logic [PTR_W-1:0]     pointer_store [TABLE_DEPTH];
      logic [10:0]          next_index;
      logic [GEN_W-1:0]     generation;
      handle_response_type  owed_q[$];
      int                   errors;

      function new();
         next_index = 11'd1;
         generation = GEN_MIN;
         errors = 0;
      endfunction

      // Apply one accepted request; return the token it issues.
      function logic [TOKEN_W-1:0] note_request(logic [1:0] code, logic [PTR_W-1:0] ptr,
                                                logic [TOKEN_W-1:0] tok);
         handle_response_type r;
         logic [GEN_W-1:0] tok_gen;
         logic [INDEX_W-1:0] tok_idx;
         r.token_out = '0;
         r.pointer_out = '0;
         r.status = ST_OK;
         tok_gen = tok[TOKEN_W-1:INDEX_W];
         tok_idx = tok[INDEX_W-1:0];
         case (code)
            REQ_REGISTER: begin
               if (ptr == '0) begin
                  r.status = ST_NULL;
               end else if (next_index >= TABLE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  pointer_store[next_index] = ptr;
                  r.token_out = {generation, INDEX_W'(next_index)};
                  next_index = next_index + 11'd1;
               end
            end
            REQ_RESOLVE: begin
               if (tok == '0 || tok_gen != generation || tok_idx == '0 ||
                   tok_idx >= INDEX_W'(next_index)) begin
                  r.status = ST_BAD_TOKEN;
               end else begin
                  r.pointer_out = pointer_store[tok_idx];
               end
            end
            REQ_RESET: begin
               next_index = 11'd1;
               generation = (generation == GEN_MAX) ? GEN_MIN : generation + 12'd1;
            end
            default: ;
         endcase
         r.generation_now = generation;
         owed_q.push_back(r);
         return r.token_out;
      endfunction

      function void check_response(logic [TOKEN_W-1:0] tok, logic [PTR_W-1:0] ptr,
                                   logic [1:0] st, logic [GEN_W-1:0] gen);
         handle_response_type e;
         if (owed_q.size() == 0) begin
            $error("response with none outstanding: token_out %h pointer_out %h", tok, ptr);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         if (e.token_out !== tok) begin
            $error("token_out: expected %h, actual %h", e.token_out, tok);
            errors++;
         end
         if (e.pointer_out !== ptr) begin
            $error("pointer_out: expected %h, actual %h", e.pointer_out, ptr);
            errors++;
         end
         if (e.status !== st) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (e.generation_now !== gen) begin
            $error("generation_now: expected %h, actual %h", e.generation_now, gen);
            errors++;
         end
      endfunction

      function int owed_count();
         return owed_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_type;
   logic [PTR_W-1:0]   req_pointer_value;
   logic [TOKEN_W-1:0] req_token_in;
   logic               rsp_valid;
   logic [TOKEN_W-1:0] rsp_token_out;
   logic [PTR_W-1:0]   rsp_pointer_out;
   logic [1:0]         rsp_status;
   logic [GEN_W-1:0]   rsp_generation_now;

   handle_scoreboard   sb;
   logic [TOKEN_W-1:0] live_tokens[$];
   logic [TOKEN_W-1:0] stale_tokens[$];
   bit                 sender_active;
   int                 burst_left;
   int                 items_sent;
   int                 cycle_count;

   generational_handle_table uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_pointer_value  (req_pointer_value),
      .req_token_in       (req_token_in),
      .rsp_valid          (rsp_valid),
      .rsp_token_out      (rsp_token_out),
      .rsp_pointer_out    (rsp_pointer_out),
      .rsp_status         (rsp_status),
      .rsp_generation_now (rsp_generation_now)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL generational_handle_table");
         $finish;
      end
   end

   // Results cannot be held off: capture on every strobe.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_response(rsp_token_out, rsp_pointer_out, rsp_status, rsp_generation_now);
      end
   end

   function automatic logic [PTR_W-1:0] rand_pointer();
      logic [PTR_W-1:0] p;
      case ($urandom_range(0, 9))
         0: p = {PTR_W{1'b1}};
         1: p = 64'd1;
         2: p = {1'b1, 63'd0};
         default: p = {$urandom, $urandom};
      endcase
      if (p == '0) p = 64'd1;
      return p;
   endfunction

   function automatic logic [TOKEN_W-1:0] pick_token();
      logic [TOKEN_W-1:0] t;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (live_tokens.size() != 0)
               t = live_tokens[$urandom_range(0, live_tokens.size() - 1)];
            else
               t = $urandom;
         end
         4: begin
            if (stale_tokens.size() != 0)
               t = stale_tokens[$urandom_range(0, stale_tokens.size() - 1)];
            else
               t = {sb.generation + 12'd1, INDEX_W'(1)};
         end
         5: t = {sb.generation, INDEX_W'(sb.next_index)};
         6: t = {sb.generation, INDEX_W'(0)};
         7: t = {sb.generation, INDEX_W'($urandom)};
         8: t = $urandom;
         default: begin
            if ($urandom_range(0, 1) == 0)
               t = '0;
            else
               t = {sb.generation, INDEX_W'($urandom_range(1, sb.next_index))};
         end
      endcase
      return t;
   endfunction

   task automatic idle_sender();
      if (sender_active) begin
         start <= 1'b0;
         sender_active = 1'b0;
      end
   endtask

   // Present one request, hold it until the transfer, then maybe open a gap.
   task automatic send_request(input logic [1:0] code, input logic [PTR_W-1:0] ptr,
                               input logic [TOKEN_W-1:0] tok);
      logic [TOKEN_W-1:0] issued;
      int gap;
      req_type <= code;
      req_pointer_value <= ptr;
      req_token_in <= tok;
      start <= 1'b1;
      sender_active = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      issued = sb.note_request(code, ptr, tok);
      items_sent++;
      if (code == REQ_REGISTER && issued != '0) live_tokens.push_back(issued);
      if (code == REQ_RESET) begin
         foreach (live_tokens[i]) stale_tokens.push_back(live_tokens[i]);
         live_tokens.delete();
         while (stale_tokens.size() > STALE_KEEP) void'(stale_tokens.pop_front());
      end
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         idle_sender();
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic drain_responses();
      idle_sender();
      while (sb.owed_count() != 0) @(posedge clock);
   endtask

   // Register a few pointers, resolve a random mix of live, stale and bad tokens, maybe rewind.
   task automatic run_session();
      int n_reg;
      int n_res;
      n_reg = $urandom_range(1, 12);
      n_res = $urandom_range(1, 12);
      repeat (n_reg) begin
         if ($urandom_range(0, 9) == 0)
            send_request(REQ_REGISTER, '0, $urandom);
         else
            send_request(REQ_REGISTER, rand_pointer(), $urandom);
      end
      repeat (n_res) send_request(REQ_RESOLVE, rand_pointer(), pick_token());
      if ($urandom_range(0, 9) < 3) send_request(REQ_RESET, rand_pointer(), $urandom);
   endtask

   task automatic run_noise();
      logic [1:0] code;
      logic [PTR_W-1:0] ptr;
      repeat ($urandom_range(1, 6)) begin
         code = 2'($urandom_range(0, 3));
         ptr = ($urandom_range(0, 3) == 0) ? '0 : rand_pointer();
         send_request(code, ptr, pick_token());
      end
   endtask

   initial begin
      int random_goal;
      sb = new();
      sender_active = 1'b0;
      burst_left = 6;
      items_sent = 0;
      cycle_count = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_type <= REQ_REGISTER;
      req_pointer_value <= '0;
      req_token_in <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes and each special case.
      send_request(REQ_RESOLVE, {PTR_W{1'b1}}, '0);
      send_request(REQ_REGISTER, '0, {TOKEN_W{1'b1}});
      send_request(REQ_REGISTER, {PTR_W{1'b1}}, '0);
      send_request(REQ_REGISTER, 64'd1, '0);
      send_request(REQ_REGISTER, {1'b1, 63'd0}, '0);
      send_request(REQ_RESOLVE, '0, {GEN_MIN, INDEX_W'(1)});
      send_request(REQ_RESOLVE, '0, {GEN_MIN, INDEX_W'(3)});
      send_request(REQ_RESOLVE, '0, {GEN_MIN, INDEX_W'(0)});
      send_request(REQ_RESOLVE, '0, {GEN_MIN, INDEX_W'(4)});
      send_request(REQ_RESOLVE, '0, {GEN_MIN + 12'd1, INDEX_W'(1)});
      send_request(REQ_RESOLVE, '0, {TOKEN_W{1'b1}});
      send_request(REQ_RESOLVE, '0, {GEN_MIN, {INDEX_W{1'b1}}});
      send_request(REQ_UNUSED, {PTR_W{1'b1}}, {TOKEN_W{1'b1}});
      send_request(REQ_RESOLVE, '0, {GEN_MIN, INDEX_W'(2)});
      send_request(REQ_RESET, {PTR_W{1'b1}}, {TOKEN_W{1'b1}});
      send_request(REQ_RESOLVE, '0, {GEN_MIN, INDEX_W'(1)});
      send_request(REQ_REGISTER, 64'h0123_4567_89AB_CDEF, '0);
      send_request(REQ_RESOLVE, '0, {GEN_MIN + 12'd1, INDEX_W'(1)});
      send_request(REQ_UNUSED, '0, '0);
      send_request(REQ_RESOLVE, '0, {GEN_MIN + 12'd1, INDEX_W'(1)});

      // Hold off until every owed response is back.
      drain_responses();

      random_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < random_goal) begin
         if ($urandom_range(0, 9) < 7)
            run_session();
         else
            run_noise();
      end

      drain_responses();
      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.owed_count() == 0)
         $display("PASS generational_handle_table");
      else
         $display("FAIL generational_handle_table");
      $finish;
   end

endmodule
